FILE: rtl/core/hsv2rgb_pkg.sv
// hsv2rgb_pkg: payload types, sector codes and fixed reciprocal constants
// for the HSV to RGB converter. No dependencies.
package hsv2rgb_pkg;

   localparam int HUE_W    = 15;
   localparam int SV_W     = 16;
   localparam int CH_W     = 8;
   localparam int SECTOR_W = 3;

   typedef struct packed {
      logic [HUE_W-1:0] hue;
      logic [SV_W-1:0]  saturation;
      logic [SV_W-1:0]  brightness;
   } hsv2rgb_req_type;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
   } hsv2rgb_rsp_type;

   // 60-degree sectors of the hue circle
   localparam logic [SECTOR_W-1:0] SECT_RED_YEL = 3'd0;
   localparam logic [SECTOR_W-1:0] SECT_YEL_GRN = 3'd1;
   localparam logic [SECTOR_W-1:0] SECT_GRN_CYN = 3'd2;
   localparam logic [SECTOR_W-1:0] SECT_CYN_BLU = 3'd3;
   localparam logic [SECTOR_W-1:0] SECT_BLU_MAG = 3'd4;
   localparam logic [SECTOR_W-1:0] SECT_MAG_RED = 3'd5;

   // hue >> (frac+2) divided by 15: exact for 13-bit dividends
   localparam int              DIV15_X_W   = 13;
   localparam int              DIV15_M_W   = 14;
   localparam logic [13:0]     DIV15_MUL   = 14'd8739;
   localparam int              DIV15_SHIFT = 17;
   localparam int              Q_W         = 10;

   // whole-sector count divided by 6: exact for 10-bit dividends
   localparam logic [10:0]     DIV6_MUL    = 11'd1366;
   localparam int              DIV6_SHIFT  = 13;
   localparam int              Q6_W        = 8;

   // channel pre-quotient (at most 15*255) divided by 15
   localparam int              NQ_W        = 12;
   localparam logic [12:0]     CHDIV_MUL   = 13'd4370;
   localparam int              CHDIV_SHIFT = 16;

   localparam int              CH_PRE_W    = CH_W + 1;
   localparam logic [CH_W-1:0] CHANNEL_MAX = 8'd255;

   function automatic logic [CH_W-1:0] clamp_channel(input logic [CH_PRE_W-1:0] c);
      clamp_channel = (c > CH_PRE_W'(CHANNEL_MAX)) ? CHANNEL_MAX : c[CH_W-1:0];
   endfunction

endpackage

FILE: rtl/core/hsv_to_rgb_convert_unit.sv
// hsv_to_rgb_convert_unit: top level of the HSV to 8-bit RGB converter,
// seven-stage pipeline. Depends on hsv2rgb_pkg, hsv2rgb_sector,
// hsv2rgb_weight and hsv2rgb_scale.
//
// Usage:
//  - req channel (req_valid/req_ready/req_data) takes one colour item:
//    hue in 1/2^HUE_FRAC_BITS degree, saturation and brightness in
//    Q1.SV_FRAC_BITS. Hue wraps at 360 degrees, S and V clamp at 1.0.
//  - rsp channel (rsp_valid/rsp_ready/rsp_data) returns red, green, blue,
//    each truncated toward zero and clamped to 0..255, one per item, in order.
//  - Path: an accepted item moves through the seven register stages in
//    order and waits in place on a stall; rsp_valid is the last stage's flag.
//  - Throughput: one item per clock while rsp_ready stays high; the seven
//    register stages each hold one item, the multipliers sit in
//    stages 1, 2, 3, 5 and 7.
//  - Each stage moves when it is empty or the stage after it moves, so
//    empty slots close up: with rsp_ready low, req_ready stays high until
//    every stage holds an item. Nothing is dropped or repeated on a stall.
//  - Reset (synchronous, active high) empties the pipeline; payload
//    registers are not cleared. There are no configuration registers.
module hsv_to_rgb_convert_unit #(
   parameter int HUE_FRAC_BITS = 6,
   parameter int SV_FRAC_BITS  = 15
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  hsv2rgb_pkg::hsv2rgb_req_type  req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output hsv2rgb_pkg::hsv2rgb_rsp_type  rsp_data
);
   import hsv2rgb_pkg::*;

   localparam int STAGES = 7;
   localparam int ONE_W  = SV_FRAC_BITS + 1;
   localparam int UNIT_W = HUE_FRAC_BITS + 6;
   localparam int M_W    = 2 * SV_FRAC_BITS + HUE_FRAC_BITS + 7;
   localparam int MP_W   = 2 * SV_FRAC_BITS + 2;

   logic [STAGES-1:0]   vld_ff, vld_in;
   logic [STAGES-1:0]   en;
   logic                in_acc, out_acc;

   logic [UNIT_W-1:0]   rem;
   logic [SECTOR_W-1:0] sec2, sec5;
   logic [ONE_W-1:0]    sat2, val2, val5;
   logic [M_W-1:0]      mq, mt;
   logic [MP_W-1:0]     mp;

   // stage advance: a stage loads when it is empty or its successor loads
   always_comb begin
      en[STAGES-1] = !vld_ff[STAGES-1] || rsp_ready;
      for (int i = STAGES - 2; i >= 0; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
   end

   always_comb begin
      for (int i = 0; i < STAGES; i++) begin
         if (!en[i]) begin
            vld_in[i] = vld_ff[i];
         end else if (i == 0) begin
            vld_in[i] = req_valid;
         end else begin
            vld_in[i] = vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = vld_ff[STAGES-1];
   assign in_acc    = req_valid && req_ready;
   assign out_acc   = rsp_valid && rsp_ready;

   // stages 1-2: clamp, sector and offset
   hsv2rgb_sector #(
      .HUE_FRAC_BITS(HUE_FRAC_BITS),
      .SV_FRAC_BITS (SV_FRAC_BITS)
   ) u_sector (
      .clock (clock),
      .en    (en[1:0]),
      .req   (req_data),
      .rem   (rem),
      .sector(sec2),
      .sat   (sat2),
      .val   (val2)
   );

   // stages 3-5: exact products
   hsv2rgb_weight #(
      .HUE_FRAC_BITS(HUE_FRAC_BITS),
      .SV_FRAC_BITS (SV_FRAC_BITS)
   ) u_weight (
      .clock   (clock),
      .en      (en[4:2]),
      .rem     (rem),
      .sector_i(sec2),
      .sat     (sat2),
      .val_i   (val2),
      .mq      (mq),
      .mt      (mt),
      .mp      (mp),
      .val_o   (val5),
      .sector_o(sec5)
   );

   // stages 6-7: scale, divide, pick, result register
   hsv2rgb_scale #(
      .HUE_FRAC_BITS(HUE_FRAC_BITS),
      .SV_FRAC_BITS (SV_FRAC_BITS)
   ) u_scale (
      .clock (clock),
      .en    (en[6:5]),
      .mq    (mq),
      .mt    (mt),
      .mp    (mp),
      .val   (val5),
      .sector(sec5),
      .rsp   (rsp_data)
   );

   // a ready sink keeps the whole pipe moving
   a_full_rate: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("req_ready low while rsp_ready high");

   // an empty first stage always takes an item
   a_head_open: assert property (@(posedge clock) disable iff (reset)
      !vld_ff[0] |-> req_ready)
      else $error("first stage empty but req_ready low");

   // items in flight change only by accepts and deliveries
   a_item_count: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> ($countones(vld_ff) ==
         $past($countones(vld_ff)) + int'($past(in_acc)) - int'($past(out_acc))))
      else $error("pipeline item count mismatch");

endmodule

FILE: rtl/core/hsv2rgb_sector.sv
// hsv2rgb_sector: stages 1-2, input clamp and split of hue into sector
// and offset within the sector. Depends on hsv2rgb_pkg.
module hsv2rgb_sector #(
   parameter int HUE_FRAC_BITS = 6,
   parameter int SV_FRAC_BITS  = 15
) (
   input  logic                              clock,
   input  logic [1:0]                        en,
   input  hsv2rgb_pkg::hsv2rgb_req_type      req,
   output logic [HUE_FRAC_BITS+5:0]          rem,
   output logic [hsv2rgb_pkg::SECTOR_W-1:0]  sector,
   output logic [SV_FRAC_BITS:0]             sat,
   output logic [SV_FRAC_BITS:0]             val
);
   import hsv2rgb_pkg::*;

   localparam int ONE_W  = SV_FRAC_BITS + 1;
   localparam int UNIT_W = HUE_FRAC_BITS + 6;
   localparam int DIVP_W = DIV15_X_W + DIV15_M_W;
   localparam int Q15_W  = Q_W + 4;
   localparam int D6P_W  = Q_W + 11;
   localparam logic [ONE_W-1:0] ONE = ONE_W'(1) << SV_FRAC_BITS;

   logic [HUE_W-1:0]     hue_ff;
   logic [Q_W-1:0]       q_ff, q_in;
   logic [ONE_W-1:0]     sat1_ff, sat1_in, val1_ff, val1_in;
   logic [DIV15_X_W-1:0] x;
   logic [DIVP_W-1:0]    xprod;

   logic [UNIT_W-1:0]    rem_ff, rem_in;
   logic [SECTOR_W-1:0]  sector_ff, sector_in;
   logic [ONE_W-1:0]     sat2_ff, val2_ff;
   logic [Q15_W-1:0]     q15;
   logic [HUE_W-1:0]     qunit, hdiff;
   logic [D6P_W-1:0]     q6prod;
   logic [Q6_W-1:0]      q6;
   logic [Q_W-1:0]       qmod;

   // stage 1: clamp to 1.0, whole sectors = (hue >> (frac+2)) / 15
   always_comb begin
      sat1_in = (17'(req.saturation) > 17'(ONE)) ? ONE : ONE_W'(req.saturation);
      val1_in = (17'(req.brightness) > 17'(ONE)) ? ONE : ONE_W'(req.brightness);
      x       = DIV15_X_W'(req.hue >> (HUE_FRAC_BITS + 2));
      xprod   = DIVP_W'(x) * DIVP_W'(DIV15_MUL);
      q_in    = xprod[DIV15_SHIFT +: Q_W];
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         hue_ff  <= req.hue;
         q_ff    <= q_in;
         sat1_ff <= sat1_in;
         val1_ff <= val1_in;
      end
   end

   // stage 2: offset = hue - q*unit, sector = q mod 6
   always_comb begin
      q15       = {q_ff, 4'b0000} - Q15_W'(q_ff);
      qunit     = HUE_W'(q15) << (HUE_FRAC_BITS + 2);
      hdiff     = hue_ff - qunit;
      rem_in    = hdiff[UNIT_W-1:0];
      q6prod    = D6P_W'(q_ff) * D6P_W'(DIV6_MUL);
      q6        = q6prod[DIV6_SHIFT +: Q6_W];
      qmod      = q_ff - Q_W'({q6, 2'b00}) - Q_W'({q6, 1'b0});
      sector_in = qmod[SECTOR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         rem_ff    <= rem_in;
         sector_ff <= sector_in;
         sat2_ff   <= sat1_ff;
         val2_ff   <= val1_ff;
      end
   end

   assign rem    = rem_ff;
   assign sector = sector_ff;
   assign sat    = sat2_ff;
   assign val    = val2_ff;

endmodule

FILE: rtl/core/hsv2rgb_weight.sv
// hsv2rgb_weight: stages 3-5, products V*(1-S), V*(unit*1-f*S) and
// V*(unit*1-(unit-f)*S) kept exact. Depends on hsv2rgb_pkg.
module hsv2rgb_weight #(
   parameter int HUE_FRAC_BITS = 6,
   parameter int SV_FRAC_BITS  = 15
) (
   input  logic                                              clock,
   input  logic [2:0]                                        en,
   input  logic [HUE_FRAC_BITS+5:0]                          rem,
   input  logic [hsv2rgb_pkg::SECTOR_W-1:0]                  sector_i,
   input  logic [SV_FRAC_BITS:0]                             sat,
   input  logic [SV_FRAC_BITS:0]                             val_i,
   output logic [2*SV_FRAC_BITS+HUE_FRAC_BITS+6:0]           mq,
   output logic [2*SV_FRAC_BITS+HUE_FRAC_BITS+6:0]           mt,
   output logic [2*SV_FRAC_BITS+1:0]                         mp,
   output logic [SV_FRAC_BITS:0]                             val_o,
   output logic [hsv2rgb_pkg::SECTOR_W-1:0]                  sector_o
);
   import hsv2rgb_pkg::*;

   localparam int ONE_W  = SV_FRAC_BITS + 1;
   localparam int UNIT_W = HUE_FRAC_BITS + 6;
   localparam int B_W    = UNIT_W + SV_FRAC_BITS;
   localparam int M_W    = ONE_W + B_W;
   localparam int MP_W   = 2 * ONE_W;
   localparam logic [ONE_W-1:0]  ONE  = ONE_W'(1) << SV_FRAC_BITS;
   localparam logic [UNIT_W-1:0] UNIT = UNIT_W'(60) << HUE_FRAC_BITS;
   localparam logic [B_W-1:0]    UONE = B_W'(UNIT) << SV_FRAC_BITS;

   logic [B_W-1:0]      pq_ff, pq_in, pt_ff, pt_in;
   logic [ONE_W-1:0]    a3_ff, v3_ff;
   logic [SECTOR_W-1:0] s3_ff;
   logic [B_W-1:0]      bq_ff, bt_ff;
   logic [ONE_W-1:0]    a4_ff, v4_ff;
   logic [SECTOR_W-1:0] s4_ff;
   logic [M_W-1:0]      mq_ff, mt_ff;
   logic [MP_W-1:0]     mp_ff;
   logic [ONE_W-1:0]    v5_ff;
   logic [SECTOR_W-1:0] s5_ff;
   logic [UNIT_W-1:0]   rem_t;

   // stage 3: f*S and (1-f)*S scaled by unit*one
   always_comb begin
      rem_t = UNIT - rem;
      pq_in = B_W'(rem) * B_W'(sat);
      pt_in = B_W'(rem_t) * B_W'(sat);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         pq_ff <= pq_in;
         pt_ff <= pt_in;
         a3_ff <= ONE - sat;
         v3_ff <= val_i;
         s3_ff <= sector_i;
      end
   end

   // stage 4: complements against unit*one
   always_ff @(posedge clock) begin
      if (en[1]) begin
         bq_ff <= UONE - pq_ff;
         bt_ff <= UONE - pt_ff;
         a4_ff <= a3_ff;
         v4_ff <= v3_ff;
         s4_ff <= s3_ff;
      end
   end

   // stage 5: times V
   always_ff @(posedge clock) begin
      if (en[2]) begin
         mq_ff <= M_W'(v4_ff) * M_W'(bq_ff);
         mt_ff <= M_W'(v4_ff) * M_W'(bt_ff);
         mp_ff <= MP_W'(v4_ff) * MP_W'(a4_ff);
         v5_ff <= v4_ff;
         s5_ff <= s4_ff;
      end
   end

   assign mq       = mq_ff;
   assign mt       = mt_ff;
   assign mp       = mp_ff;
   assign val_o    = v5_ff;
   assign sector_o = s5_ff;

endmodule

FILE: rtl/core/hsv2rgb_scale.sv
// hsv2rgb_scale: stages 6-7, scale by 255, truncating divide, clamp and
// per-sector channel pick into the result register. Depends on hsv2rgb_pkg.
module hsv2rgb_scale #(
   parameter int HUE_FRAC_BITS = 6,
   parameter int SV_FRAC_BITS  = 15
) (
   input  logic                                     clock,
   input  logic [1:0]                               en,
   input  logic [2*SV_FRAC_BITS+HUE_FRAC_BITS+6:0]  mq,
   input  logic [2*SV_FRAC_BITS+HUE_FRAC_BITS+6:0]  mt,
   input  logic [2*SV_FRAC_BITS+1:0]                mp,
   input  logic [SV_FRAC_BITS:0]                    val,
   input  logic [hsv2rgb_pkg::SECTOR_W-1:0]         sector,
   output hsv2rgb_pkg::hsv2rgb_rsp_type             rsp
);
   import hsv2rgb_pkg::*;

   localparam int ONE_W = SV_FRAC_BITS + 1;
   localparam int M_W   = 2 * SV_FRAC_BITS + HUE_FRAC_BITS + 7;
   localparam int MP_W  = 2 * SV_FRAC_BITS + 2;
   localparam int SH    = HUE_FRAC_BITS + 2 + 2 * SV_FRAC_BITS;
   localparam int CP_W  = NQ_W + 13;

   logic [M_W+7:0]      q255, t255;
   logic [MP_W+7:0]     p255;
   logic [ONE_W+7:0]    v255;
   logic [NQ_W-1:0]     nq_ff, nt_ff;
   logic [CH_W-1:0]     cp_ff, cv_ff, sel_cp, sel_cv;
   logic [SECTOR_W-1:0] sec_ff;
   logic [CP_W-1:0]     qprod, tprod;
   logic [CH_W-1:0]     cq, ct;
   hsv2rgb_rsp_type     rsp_ff, rsp_in;

   // stage 6: x*255, drop the power-of-two part of the denominator
   always_comb begin
      q255 = {mq, 8'h00} - (M_W+8)'(mq);
      t255 = {mt, 8'h00} - (M_W+8)'(mt);
      p255 = {mp, 8'h00} - (MP_W+8)'(mp);
      v255 = {val, 8'h00} - (ONE_W+8)'(val);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         nq_ff  <= q255[SH +: NQ_W];
         nt_ff  <= t255[SH +: NQ_W];
         cp_ff  <= clamp_channel(p255[2*SV_FRAC_BITS +: CH_PRE_W]);
         cv_ff  <= clamp_channel(v255[SV_FRAC_BITS +: CH_PRE_W]);
         sec_ff <= sector;
      end
   end

   // stage 7: remaining /15, then pick channels by sector
   always_comb begin
      qprod  = CP_W'(nq_ff) * CP_W'(CHDIV_MUL);
      tprod  = CP_W'(nt_ff) * CP_W'(CHDIV_MUL);
      cq     = clamp_channel(qprod[CHDIV_SHIFT +: CH_PRE_W]);
      ct     = clamp_channel(tprod[CHDIV_SHIFT +: CH_PRE_W]);
      sel_cp = cp_ff;
      sel_cv = cv_ff;
      case (sec_ff)
         SECT_RED_YEL: rsp_in = '{red: sel_cv, green: ct,     blue: sel_cp};
         SECT_YEL_GRN: rsp_in = '{red: cq,     green: sel_cv, blue: sel_cp};
         SECT_GRN_CYN: rsp_in = '{red: sel_cp, green: sel_cv, blue: ct};
         SECT_CYN_BLU: rsp_in = '{red: sel_cp, green: cq,     blue: sel_cv};
         SECT_BLU_MAG: rsp_in = '{red: ct,     green: sel_cp, blue: sel_cv};
         default:      rsp_in = '{red: sel_cv, green: sel_cp, blue: cq};
      endcase
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

FILE: tb/sv/tb_hsv_to_rgb_convert_unit.sv
`timescale 1ns / 1ps
// tb_hsv_to_rgb_convert_unit: self-checking bench for the HSV to RGB converter.
// Needs hsv2rgb_pkg and hsv_to_rgb_convert_unit; predicts every colour in exact
// integer arithmetic and checks the rgb items in order.
module tb_hsv_to_rgb_convert_unit;
   import hsv2rgb_pkg::*;

   localparam int HUE_FRAC      = 6;
   localparam int SV_FRAC       = 15;
   localparam int RESET_CYCLES  = 12;
   localparam int HOLD_AT       = 100;   // accepted colours before the long rsp hold
   localparam int HOLD_LEN      = 60;    // well past the 7-deep pipeline
   localparam int DRAIN_CYCLES  = 20;    // leave margin for the pipeline to drain
   localparam int STALL_LIMIT   = 2000;  // cycles with no handshake at all

   logic            clock     = 1'b0;
   logic            reset     = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   hsv2rgb_req_type req_data  = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   hsv2rgb_rsp_type rsp_data;

   hsv2rgb_req_type colors_to_send[$];   // filled by the stimulus block
   hsv2rgb_rsp_type rgb_expected[$];     // one entry per accepted colour

   logic req_fired    = 1'b0;  // req handshake at the last rising edge
   logic calm_tail    = 1'b0;  // no idling on either side once set
   logic hold_done    = 1'b0;
   int   hold_left    = 0;
   int   send_gap     = 0;
   int   recv_gap     = 0;
   int   req_accepts  = 0;
   int   mismatches   = 0;
   int   stall_cycles = 0;

   always #1 clock = ~clock;

   hsv_to_rgb_convert_unit #(
      .HUE_FRAC_BITS(HUE_FRAC),
      .SV_FRAC_BITS (SV_FRAC)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   // Truncate an exact ratio toward zero and clamp to one 8-bit channel.
   function automatic logic [CH_W-1:0] ratio_to_channel(longint unsigned num,
                                                        longint unsigned den);
      longint unsigned c;
      c = (den != 0) ? (num / den) : 0;
      return (c > 255) ? CHANNEL_MAX : c[CH_W-1:0];
   endfunction

   // Expected rgb for one colour. Every channel is kept as an exact ratio
   // scaled by 255 and truncated once; the largest numerator is about 2^50,
   // so 64-bit unsigned math holds it with room to spare.
   function automatic hsv2rgb_rsp_type hsv_to_rgb_predict(hsv2rgb_req_type c);
      longint unsigned one, unit, h, sect, rem, s, v, den;
      logic [CH_W-1:0] cv, cp, cq, ct;
      logic [SECTOR_W-1:0] sector;
      hsv2rgb_rsp_type rgb;
      one  = 64'd1 << SV_FRAC;
      unit = 64'd60 << HUE_FRAC;
      h    = c.hue;
      h    = h % (unit * 6);            // 360 degrees and above wrap around
      sect = h / unit;
      rem  = h - sect * unit;
      s    = c.saturation;
      v    = c.brightness;
      if (s > one) s = one;             // S and V saturate at 1.0
      if (v > one) v = one;
      den  = unit * one * one;
      cv = ratio_to_channel(255 * v, one);
      cp = ratio_to_channel(255 * v * (one - s), one * one);
      cq = ratio_to_channel(255 * v * (unit * one - rem * s), den);
      ct = ratio_to_channel(255 * v * (unit * one - (unit - rem) * s), den);
      sector = sect[SECTOR_W-1:0];
      case (sector)
         SECT_RED_YEL: rgb = '{red: cv, green: ct, blue: cp};
         SECT_YEL_GRN: rgb = '{red: cq, green: cv, blue: cp};
         SECT_GRN_CYN: rgb = '{red: cp, green: cv, blue: ct};
         SECT_CYN_BLU: rgb = '{red: cp, green: cq, blue: cv};
         SECT_BLU_MAG: rgb = '{red: ct, green: cp, blue: cv};
         default:      rgb = '{red: cv, green: cp, blue: cq};
      endcase
      return rgb;
   endfunction

   // Random colour. Most are in range; some hug sector edges, some pin S/V
   // to their corners, and some use every bit pattern the fields can carry
   // (hue past 360, S and V past 1.0).
   function automatic hsv2rgb_req_type random_color();
      hsv2rgb_req_type c;
      int              h;
      c.hue        = HUE_W'($urandom_range(0, 23040));
      c.saturation = SV_W'($urandom_range(0, 32768));
      c.brightness = SV_W'($urandom_range(0, 32768));
      case ($urandom_range(0, 9))
         0: begin
            c.hue        = HUE_W'($urandom);
            c.saturation = SV_W'($urandom);
            c.brightness = SV_W'($urandom);
         end
         1: begin
            h = 3840 * $urandom_range(0, 6) + $urandom_range(0, 4) - 2;
            c.hue = HUE_W'((h < 0) ? 0 : h);
         end
         2: begin
            c.saturation = SV_W'(($urandom_range(0, 1) == 0) ? 0 : 32768 - $urandom_range(0, 1));
            c.brightness = SV_W'(($urandom_range(0, 1) == 0) ? 32768 : $urandom_range(0, 1));
         end
         default: ;
      endcase
      return c;
   endfunction

   task automatic push_color(int h, int s, int v);
      hsv2rgb_req_type c;
      c.hue        = HUE_W'(h);
      c.saturation = SV_W'(s);
      c.brightness = SV_W'(v);
      colors_to_send.push_back(c);
   endtask

   task automatic push_random(int count);
      repeat (count) colors_to_send.push_back(random_color());
   endtask

   // Returns after a falling edge once nothing is queued, offered or in flight;
   // a delay after the edge lets the sender's update settle first.
   task automatic wait_drained();
      do begin
         @(negedge clock);
         #0.5;
      end while (colors_to_send.size() != 0 || req_valid || rgb_expected.size() != 0);
   endtask

   // Sender: offers queued colours, changes only at the falling edge.
   // A new item (or an idle burst) starts only after the current one was
   // taken; no idle burst starts during the rsp hold or in the tail.
   always @(negedge clock) begin : sender
      hsv2rgb_req_type next_item;
      logic            next_valid;
      next_item  = req_data;
      next_valid = req_valid;
      if (reset) begin
         next_valid = 1'b0;
      end else if (!req_valid || req_fired) begin
         next_valid = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
         end else if (colors_to_send.size() != 0) begin
            if (!calm_tail && hold_left == 0 && $urandom_range(0, 5) == 0) begin
               send_gap = $urandom_range(0, 6);
            end else begin
               next_item  = colors_to_send.pop_front();
               next_valid = 1'b1;
            end
         end
      end
      req_valid <= next_valid;
      req_data  <= next_item;
   end

   // Receiver: random stall bursts, plus one long hold once enough colours
   // went in, so the pipeline fills and req_ready has to drop.
   always @(negedge clock) begin : receiver
      logic ready_next;
      ready_next = 1'b1;
      if (reset) begin
         ready_next = 1'b0;
      end else if (hold_left > 0) begin
         ready_next = 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && req_accepts >= HOLD_AT) begin
         ready_next = 1'b0;
         hold_done <= 1'b1;
         hold_left <= HOLD_LEN - 1;
      end else if (recv_gap > 0) begin
         ready_next = 1'b0;
         recv_gap <= recv_gap - 1;
      end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
         ready_next = 1'b0;
         recv_gap <= $urandom_range(0, 6);
      end
      rsp_ready <= ready_next;
   end

   // Monitor: both handshakes are sampled at the rising edge. Each accepted
   // colour queues its prediction; each rgb item is matched to the oldest.
   always @(posedge clock) begin : monitor
      hsv2rgb_rsp_type want;
      if (reset) begin
         req_fired    <= 1'b0;
         stall_cycles <= 0;
      end else begin
         req_fired <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            rgb_expected.push_back(hsv_to_rgb_predict(req_data));
            req_accepts++;
         end
         if (rsp_valid && rsp_ready) begin
            if (rgb_expected.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: rgb item %0d/%0d/%0d with no colour outstanding",
                           $realtime, rsp_data.red, rsp_data.green, rsp_data.blue);
            end else begin
               want = rgb_expected.pop_front();
               if (rsp_data.red !== want.red || rsp_data.green !== want.green ||
                   rsp_data.blue !== want.blue) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: rgb expected %0d/%0d/%0d got %0d/%0d/%0d",
                              $realtime, want.red, want.green, want.blue,
                              rsp_data.red, rsp_data.green, rsp_data.blue);
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
      end
   end

   // Watchdog: a hung handshake ends the run.
   initial begin : watchdog
      wait (!reset);
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("end of test: mismatches");
      $finish;
   end

   initial begin : stimulus
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: black, pure red, exactly 360, just below 360, all ones
      push_color(0, 0, 0);
      push_color(0, 32768, 32768);
      push_color(23040, 32768, 32768);
      push_color(23039, 32768, 32768);
      push_color(32767, 65535, 65535);
      // sector edges, both sides of the first one
      push_color(3839, 32768, 32768);
      push_color(3840, 32768, 32768);
      push_color(7680, 32768, 32768);
      push_color(11520, 32768, 32768);
      push_color(15360, 32768, 32768);
      push_color(19200, 32768, 32768);
      // middle of each sector, half saturation
      for (int k = 0; k < 6; k++) push_color(1920 + 3840 * k, 16384, 32768);
      // grey, black with colour, S and V past 1.0
      push_color(1920, 0, 32768);
      push_color(1920, 32768, 0);
      push_color(5000, 40000, 50000);
      // hue just past 360 and well past it
      push_color(23041, 20000, 30000);
      push_color(26880, 32768, 32768);
      push_color(100, 32767, 32767);
      push_color(12345, 1, 1);
      wait_drained();

      // Random body; the long rsp hold falls in the first chunk. The sender
      // then sits idle until every rgb item is back before going on.
      @(posedge clock);
      push_random(300);
      wait_drained();
      @(posedge clock);
      push_random(200);
      wait_drained();

      // Tail at full rate with no idling either side.
      calm_tail <= 1'b1;
      @(posedge clock);
      push_random(100);
      wait_drained();

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0 && rgb_expected.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
